FILE: src/rba_pkg.sv
package rba_pkg;

    // default width of the internal ratio and convergent values
    localparam int VALUE_WIDTH_DEF = 32;

    // width of the ports and of the limit registers
    localparam int PORT_WIDTH = 32;

    // reset value of both limit registers
    localparam logic [PORT_WIDTH-1:0] LIMIT_RESET = 32'd65535;

    // configuration register indexes
    localparam logic REG_NUM_LIMIT = 1'b0;
    localparam logic REG_DEN_LIMIT = 1'b1;

    // commands from the sequencer to the euclid unit
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic advance;
    } ctrl_t;

    // status from the euclid unit to the sequencer
    typedef struct packed {
        logic over_limit;
        logic d_zero;
        logic div_last;
        logic term_ovf;
    } sts_t;

endpackage

FILE: src/rba_euclid_unit.sv
module rba_euclid_unit #(
    parameter int VALUE_WIDTH = rba_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  rba_pkg::ctrl_t                  ctrl,
    input  logic [VALUE_WIDTH-1:0]          load_num,
    input  logic [VALUE_WIDTH-1:0]          load_den,
    input  logic [rba_pkg::PORT_WIDTH-1:0]  num_limit,
    input  logic [rba_pkg::PORT_WIDTH-1:0]  den_limit,
    output rba_pkg::sts_t                   sts,
    output logic [VALUE_WIDTH-1:0]          p_cur,
    output logic [VALUE_WIDTH-1:0]          q_cur,
    output logic [VALUE_WIDTH-1:0]          p_prev,
    output logic [VALUE_WIDTH-1:0]          q_prev
);

    localparam int W     = VALUE_WIDTH;
    localparam int CW    = (W > rba_pkg::PORT_WIDTH) ? W : rba_pkg::PORT_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     num_reg;
    logic [W-1:0]     den_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     accp_reg;
    logic [W-1:0]     accq_reg;
    logic             ovp_reg;
    logic             ovq_reg;
    logic [W-1:0]     pp_reg;
    logic [W-1:0]     pc_reg;
    logic [W-1:0]     qp_reg;
    logic [W-1:0]     qc_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [W:0]       rem_sh;
    logic [W:0]       diff;
    logic             qbit;
    logic [W-1:0]     rem_next;
    logic [W:0]       macp;
    logic [W:0]       macq;
    logic [W:0]       sump;
    logic [W:0]       sumq;

    // restoring divide step, one quotient bit per cycle, msb first
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[W-1]};
        diff     = rem_sh - {1'b0, den_reg};
        qbit     = ~diff[W];
        rem_next = qbit ? diff[W-1:0] : rem_sh[W-1:0];
    end

    // horner multiply-accumulate of the quotient bits into both convergents
    always_comb
    begin
        macp = {1'b0, accp_reg[W-2:0], 1'b0} + (qbit ? {1'b0, pc_reg} : '0);
        macq = {1'b0, accq_reg[W-2:0], 1'b0} + (qbit ? {1'b0, qc_reg} : '0);
        sump = {1'b0, accp_reg} + {1'b0, pp_reg};
        sumq = {1'b0, accq_reg} + {1'b0, qp_reg};
    end

    // status toward the sequencer
    always_comb
    begin
        sts.over_limit = (CW'(pc_reg) > CW'(num_limit)) || (CW'(qc_reg) > CW'(den_limit));
        sts.d_zero     = (den_reg == '0);
        sts.div_last   = (cnt_reg == '0);
        sts.term_ovf   = ovp_reg | ovq_reg | sump[W] | sumq[W];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            num_reg <= load_num;
            den_reg <= load_den;
            pp_reg  <= '0;
            pc_reg  <= W'(1);
            qp_reg  <= W'(1);
            qc_reg  <= '0;
        end
        if (ctrl.div_start)
        begin
            rem_reg  <= '0;
            accp_reg <= '0;
            accq_reg <= '0;
            ovp_reg  <= 1'b0;
            ovq_reg  <= 1'b0;
            cnt_reg  <= CNT_W'(W - 1);
        end
        if (ctrl.div_step)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[W-2:0], 1'b0};
            accp_reg <= macp[W-1:0];
            accq_reg <= macq[W-1:0];
            ovp_reg  <= ovp_reg | accp_reg[W-1] | macp[W];
            ovq_reg  <= ovq_reg | accq_reg[W-1] | macq[W];
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        if (ctrl.advance)
        begin
            num_reg <= den_reg;
            den_reg <= rem_reg;
            pp_reg  <= pc_reg;
            pc_reg  <= sump[W-1:0];
            qp_reg  <= qc_reg;
            qc_reg  <= sumq[W-1:0];
        end
    end

    assign p_cur  = pc_reg;
    assign q_cur  = qc_reg;
    assign p_prev = pp_reg;
    assign q_prev = qp_reg;

endmodule

FILE: src/rational_best_approximation_unit.sv
// Best rational approximation of given_num / given_den by continued-fraction
// convergents, with numerator and denominator bounded by two limit registers.
// Input channel: in_valid / in_stall with given_num and given_den; a beat is
// taken when in_valid is high and in_stall low. in_stall stays high from the
// accepted beat until the result has moved into the output register.
// Output channel: out_valid / out_stall with best_num and best_den, held in
// an output register; while the receiver stalls the result stays put, and the
// block already takes the next input beat, holding its own result until the
// output register frees up.
// Sequence: each Euclid step runs a check state, a bit-serial divide with the
// convergent updates accumulated alongside the quotient bits, and a final add
// state. One item is worked on at a time.
// Configuration: cfg_write_en, cfg_index, cfg_data write the limits; the user
// must write them only while idle, since the block does not enforce this.
// Reset sets both limits to 65535 and empties the pipeline.
module rational_best_approximation_unit #(
    parameter int VALUE_WIDTH = rba_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic                            cfg_index,
    input  logic [rba_pkg::PORT_WIDTH-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rba_pkg::PORT_WIDTH-1:0]  given_num,
    input  logic [rba_pkg::PORT_WIDTH-1:0]  given_den,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rba_pkg::PORT_WIDTH-1:0]  best_num,
    output logic [rba_pkg::PORT_WIDTH-1:0]  best_den
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = rba_pkg::PORT_WIDTH;
    localparam int CW = (W > PW) ? W : PW;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_ADD    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic           use_prev_reg, use_prev_next;
    logic [PW-1:0]  num_limit_reg;
    logic [PW-1:0]  den_limit_reg;
    logic           out_valid_reg;
    logic [PW-1:0]  best_num_reg;
    logic [PW-1:0]  best_den_reg;

    rba_pkg::ctrl_t ctrl;
    rba_pkg::sts_t  sts;
    logic [W-1:0]   p_cur, q_cur, p_prev, q_prev;
    logic [CW-1:0]  num_in_ext, den_in_ext;
    logic [CW-1:0]  res_num_ext, res_den_ext;
    logic           in_accept;
    logic           out_load;

    assign in_accept  = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign num_in_ext = CW'(given_num);
    assign den_in_ext = CW'(given_den);

    // euclid datapath
    rba_euclid_unit #(
        .VALUE_WIDTH(W)
    ) u_euclid (
        .clk      (clk),
        .ctrl     (ctrl),
        .load_num (num_in_ext[W-1:0]),
        .load_den (den_in_ext[W-1:0]),
        .num_limit(num_limit_reg),
        .den_limit(den_limit_reg),
        .sts      (sts),
        .p_cur    (p_cur),
        .q_cur    (q_cur),
        .p_prev   (p_prev),
        .q_prev   (q_prev)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        use_prev_next  = use_prev_reg;
        ctrl           = '0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.over_limit)
                begin
                    use_prev_next = 1'b1;
                    state_next    = ST_FINISH;
                end
                else if (sts.d_zero)
                begin
                    use_prev_next = 1'b0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (sts.term_ovf)
                begin
                    use_prev_next = 1'b0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            use_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            use_prev_reg <= use_prev_next;
        end
    end

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_limit_reg <= rba_pkg::LIMIT_RESET;
            den_limit_reg <= rba_pkg::LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                rba_pkg::REG_NUM_LIMIT: num_limit_reg <= cfg_data;
                rba_pkg::REG_DEN_LIMIT: den_limit_reg <= cfg_data;
                default:                num_limit_reg <= num_limit_reg;
            endcase
        end
    end

    // chosen convergent, truncated or extended to port width
    assign res_num_ext = use_prev_reg ? CW'(p_prev) : CW'(p_cur);
    assign res_den_ext = use_prev_reg ? CW'(q_prev) : CW'(q_cur);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            best_num_reg <= res_num_ext[PW-1:0];
            best_den_reg <= res_den_ext[PW-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign best_num  = best_num_reg;
    assign best_den  = best_den_reg;

`ifndef NO_ASSERTIONS
    // an accepted beat always starts with a limit check
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_CHECK)
        else $error("accepted beat did not start a check");

    // the divider never runs on a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> !sts.d_zero)
        else $error("divide step with zero divisor");

    // a new result only appears after the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside finish");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !out_load)
        else $error("stalled result overwritten");
`endif

endmodule

FILE: test/rational_best_approximation_unit_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
} fraction_t;

// predicts the best bounded convergent and checks results in order
class fraction_chk;
    logic [31:0] num_limit;
    logic [31:0] den_limit;
    fraction_t   expected_fractions[$];
    int          mismatches;

    function new();
        num_limit  = rba_pkg::LIMIT_RESET;
        den_limit  = rba_pkg::LIMIT_RESET;
        mismatches = 0;
    endfunction

    function void set_limit(logic idx, logic [31:0] value);
        if (idx == rba_pkg::REG_NUM_LIMIT)
            num_limit = value;
        else
            den_limit = value;
    endfunction

    // walk the convergents of num / den until the remainder is zero, a limit is passed or a term overflows
    function fraction_t best_fraction(logic [31:0] num, logic [31:0] den);
        logic [63:0]  vmask;
        logic [63:0]  n;
        logic [63:0]  d;
        logic [63:0]  quot;
        logic [63:0]  rem;
        logic [63:0]  p_prev;
        logic [63:0]  p_cur;
        logic [63:0]  q_prev;
        logic [63:0]  q_cur;
        logic [127:0] p_next;
        logic [127:0] q_next;
        logic         done;
        fraction_t    f;
        vmask  = (64'd1 << rba_pkg::VALUE_WIDTH_DEF) - 64'd1;
        n      = 64'(num) & vmask;
        d      = 64'(den) & vmask;
        p_prev = 64'd0;
        p_cur  = 64'd1;
        q_prev = 64'd1;
        q_cur  = 64'd0;
        done   = 1'b0;
        while (!done)
        begin
            if (p_cur > 64'(num_limit) || q_cur > 64'(den_limit))
            begin
                // newest convergent too big: fall back one step
                p_cur = p_prev;
                q_cur = q_prev;
                done  = 1'b1;
            end
            else if (d == 64'd0)
            begin
                done = 1'b1;
            end
            else
            begin
                quot   = n / d;
                rem    = n % d;
                n      = d;
                d      = rem;
                p_next = 128'(quot) * 128'(p_cur) + 128'(p_prev);
                q_next = 128'(quot) * 128'(q_cur) + 128'(q_prev);
                // a term wider than the datapath counts as over every limit
                if (p_next > 128'(vmask) || q_next > 128'(vmask))
                begin
                    done = 1'b1;
                end
                else
                begin
                    p_prev = p_cur;
                    p_cur  = p_next[63:0];
                    q_prev = q_cur;
                    q_cur  = q_next[63:0];
                end
            end
        end
        f.num = p_cur[31:0];
        f.den = q_cur[31:0];
        return f;
    endfunction

    function void note_input(logic [31:0] num, logic [31:0] den);
        expected_fractions.push_back(best_fraction(num, den));
    endfunction

    function void check_result(logic [31:0] got_num, logic [31:0] got_den);
        fraction_t want;
        if (expected_fractions.size() == 0)
        begin
            $error("unexpected result %0d/%0d with nothing pending", got_num, got_den);
            mismatches++;
            return;
        end
        want = expected_fractions.pop_front();
        if (got_num !== want.num)
        begin
            $error("best_num mismatch: expected %0d, got %0d", want.num, got_num);
            mismatches++;
        end
        if (got_den !== want.den)
        begin
            $error("best_den mismatch: expected %0d, got %0d", want.den, got_den);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_fractions.size();
    endfunction
endclass

module rational_best_approximation_unit_tb;

    localparam int W              = rba_pkg::PORT_WIDTH;
    localparam int TIMEOUT_CYCLES = 3_000_000;
    localparam int TAIL_CYCLES    = 4 * (rba_pkg::VALUE_WIDTH_DEF + 2);

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_write_en;
    logic         cfg_index;
    logic [W-1:0] cfg_data;
    logic         in_valid;
    logic         in_stall;
    logic [W-1:0] given_num;
    logic [W-1:0] given_den;
    logic         out_valid;
    logic         out_stall;
    logic [W-1:0] best_num;
    logic [W-1:0] best_den;

    fraction_chk  chk;
    stall_mode_t  stall_mode = STALL_NONE;
    int           stall_left = 0;
    int           burst_left = 0;
    int           cycle_count = 0;
    int           ratio_count = 0;
    int           zero_den_count = 0;
    int           setting_count = 1;

    rational_best_approximation_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .given_num    (given_num),
        .given_den    (given_den),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .best_num     (best_num),
        .best_den     (best_den)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern: quiet, light and heavy stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            stall_left = $urandom_range(20, 400);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 1) == 1);
            default:     out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // result beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            chk.check_result(best_num, best_den);
    end

    task automatic write_limit(input logic idx, input logic [W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        chk.set_limit(idx, value);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [W-1:0] num_lim, input logic [W-1:0] den_lim);
        write_limit(rba_pkg::REG_NUM_LIMIT, num_lim);
        write_limit(rba_pkg::REG_DEN_LIMIT, den_lim);
        setting_count++;
    endtask

    // one input beat, preceded by a gap when a burst runs out
    task automatic send(input logic [W-1:0] num, input logic [W-1:0] den);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 30);
            burst_left = $urandom_range(1, 10);
        end
        else
        begin
            gap = 0;
        end
        burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid  <= 1'b0;
            given_num <= $urandom();
            given_den <= $urandom();
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        given_num <= num;
        given_den <= den;
        do
            @(posedge clk);
        while (in_stall);
        chk.note_input(num, den);
        ratio_count++;
        if (den == '0)
            zero_den_count++;
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (chk.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [W-1:0] random_value();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return '0;
            1:       return '1;
            2:       return 32'd1;
            3, 4:    return $urandom_range(1, 65535);
            5, 6:    return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // random values, near-one ratios and deep ratios so long expansions get exercised
    function automatic fraction_t random_ratio();
        int          kind;
        logic [63:0] h0;
        logic [63:0] h1;
        logic [63:0] k0;
        logic [63:0] k1;
        logic [63:0] term;
        logic [63:0] h_next;
        logic [63:0] k_next;
        logic        grow;
        fraction_t   f;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            f.num = random_value();
            f.den = random_value();
        end
        else if (kind < 7)
        begin
            f.den = $urandom();
            f.num = f.den + 32'($urandom_range(0, 15));
        end
        else
        begin
            // build the ratio from small partial quotients
            h0   = 64'd0;
            h1   = 64'd1;
            k0   = 64'd1;
            k1   = 64'd0;
            grow = 1'b1;
            repeat ($urandom_range(5, 45))
            begin
                if (grow)
                begin
                    term   = $urandom_range(1, 4);
                    h_next = term * h1 + h0;
                    k_next = term * k1 + k0;
                    if (h_next > 64'hFFFF_FFFF || k_next > 64'hFFFF_FFFF)
                    begin
                        grow = 1'b0;
                    end
                    else
                    begin
                        h0 = h1;
                        h1 = h_next;
                        k0 = k1;
                        k1 = k_next;
                    end
                end
            end
            if ($urandom_range(0, 1) == 1)
            begin
                f.num = h1[31:0];
                f.den = k1[31:0];
            end
            else
            begin
                f.num = k1[31:0];
                f.den = h1[31:0];
            end
        end
        return f;
    endfunction

    // random ratios, draining once halfway through
    task automatic run_random(input int count);
        fraction_t f;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                go_idle();
                wait_drained();
            end
            f = random_ratio();
            send(f.num, f.den);
        end
        go_idle();
        wait_drained();
    endtask

    initial
    begin
        chk          = new();
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = rba_pkg::REG_NUM_LIMIT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        given_num    = '0;
        given_den    = '0;
        out_stall    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limits: field extremes and special ratios
        send('0, '0);
        send(32'd5, '0);
        send('0, 32'd7);
        send(32'd1, 32'd1);
        send('1, '1);
        send('1, 32'd1);
        send(32'd1, '1);
        send(32'd65535, 32'd1);
        send(32'd65536, 32'd1);
        send(32'd1, 32'd65536);
        send(32'd355, 32'd113);
        send(32'd22, 32'd7);
        send(32'd314159265, 32'd100000000);
        send(32'd2971215073, 32'd1836311903);
        send(32'd1836311903, 32'd2971215073);
        send(32'hAAAA_AAAA, 32'h5555_5555);
        send(32'h5555_5555, 32'hAAAA_AAAA);
        send(32'h8000_0000, 32'h7FFF_FFFF);
        send(32'd123456789, 32'd987654321);
        send(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        run_random(85);

        // widest limits: full expansions
        set_limits('1, '1);
        send(32'd2971215073, 32'd1836311903);
        send('1, 32'd1);
        send(32'd1, '1);
        send(32'hFFFF_FFFE, '1);
        send('0, '0);
        run_random(70);

        // tight limits: both bounds one
        set_limits(32'd1, 32'd1);
        send(32'd3, 32'd2);
        send(32'd1, 32'd2);
        send(32'd7, '0);
        run_random(20);

        // small numerator bound, large denominator bound
        set_limits($urandom_range(1, 1000), $urandom() | 32'h0001_0000);
        run_random(35);

        // large numerator bound, small denominator bound
        set_limits($urandom() | 32'h0001_0000, $urandom_range(1, 1000));
        run_random(35);

        // zero numerator limit: even the start convergent is over
        set_limits('0, 32'd65535);
        send('0, '0);
        send(32'd9, '0);
        send(32'd3, 32'd4);
        run_random(10);

        // quiet tail to catch stray results
        repeat (TAIL_CYCLES) @(posedge clk);
        if (chk.pending() != 0)
        begin
            $error("%0d expected results never arrived", chk.pending());
            chk.mismatches++;
        end

        $display("covered %0d ratios (%0d with zero denominator) under %0d limit settings",
                 ratio_count, zero_den_count, setting_count);
        $display("%0d cycles run, %0d mismatches", cycle_count, chk.mismatches);
        if (chk.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
